// ----- sv/mid_pkg.sv -----
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types and constants for the modular inverse / divide block:
// opcode codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package mid_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_GCD  = 2'd0,
        OP_INV  = 2'd1,
        OP_DIV  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic div_start;  // start a division
        logic div_mod;    // division is a mod m (else r0 / r1)
        logic div_step;   // one quotient bit
        logic update;     // euclid register rotate
        logic mul_start;  // start modular multiply
        logic mul_step;   // one multiplier bit
        logic out_load;   // capture result into output registers
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic r1_zero;    // euclid loop finished
        logic need_mul;   // divide request with an existing inverse
    } t_status;

endpackage

// ----- sv/mid_dpath.sv -----
// ----------------------------------------------------------------------------
// mid_dpath
// Datapath: euclid registers, bit-serial restoring divider with quotient
// times coefficient accumulation, inverse normalization, shift-add modular
// multiplier and result registers.
// ----------------------------------------------------------------------------
module mid_dpath #(
    parameter int DATA_WIDTH = mid_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  mid_pkg::t_cmd                i_cmd,
    output mid_pkg::t_status             o_status,
    input  logic [1:0]                   i_opcode,
    input  logic [DATA_WIDTH-2:0]        i_value_a,
    input  logic [DATA_WIDTH-2:0]        i_value_b,
    input  logic [DATA_WIDTH-2:0]        i_modulus,
    output logic [DATA_WIDTH-2:0]        o_gcd_value,
    output logic signed [DATA_WIDTH-1:0] o_coeff_x,
    output logic signed [DATA_WIDTH-1:0] o_coeff_y,
    output logic [DATA_WIDTH-2:0]        o_result_value,
    output logic                         o_result_valid
);
    import mid_pkg::*;

    localparam int OW = DATA_WIDTH - 1;
    localparam int CW = DATA_WIDTH;

    t_opcode                r_op;
    logic [OW-1:0]          r_a;
    logic [OW-1:0]          r_m;
    logic [OW-1:0]          r_r0, r_r1;
    logic signed [CW-1:0]   r_s0, r_s1, r_t0, r_t1;
    logic [OW-1:0]          r_dvd, r_dvs, r_rem;
    logic signed [CW-1:0]   r_acc_s, r_acc_t;
    logic [OW-1:0]          r_mp, r_mq, r_macc;

    logic [OW-1:0]          r_o_gcd, r_o_value;
    logic signed [CW-1:0]   r_o_x, r_o_y;
    logic                   r_o_valid;

    logic [OW:0]            rem_sh;
    logic                   q_bit;
    logic [OW:0]            rem_diff;
    logic [OW-1:0]          n_rem;

    logic signed [CW:0]     x_ext, m_ext, x_plus_m, x_minus_m;
    logic [OW-1:0]          inv;

    logic [OW:0]            m_wide, macc_sum, mp_dbl;
    logic [OW-1:0]          n_macc, n_mp;

    logic                   inv_ok;
    logic [OW-1:0]          res_value;
    logic                   res_valid;

    // restoring divider step
    always_comb begin
        rem_sh   = {r_rem, r_dvd[OW-1]};
        q_bit    = (rem_sh >= {1'b0, r_dvs});
        rem_diff = rem_sh - {1'b0, r_dvs};
        n_rem    = q_bit ? rem_diff[OW-1:0] : rem_sh[OW-1:0];
    end

    // bring x into 0 .. m-1, |x| <= m
    always_comb begin
        x_ext     = {r_s0[CW-1], r_s0};
        m_ext     = {2'b00, r_m};
        x_plus_m  = x_ext + m_ext;
        x_minus_m = x_ext - m_ext;
        if (x_ext < 0) begin
            inv = x_plus_m[OW-1:0];
        end else if (x_ext >= m_ext) begin
            inv = x_minus_m[OW-1:0];
        end else begin
            inv = x_ext[OW-1:0];
        end
    end

    // lsb-first modular multiply step
    always_comb begin
        m_wide   = {1'b0, r_m};
        macc_sum = {1'b0, r_macc} + {1'b0, r_mp};
        mp_dbl   = {r_mp, 1'b0};
        if (r_mq[0]) begin
            n_macc = (macc_sum >= m_wide) ? OW'(macc_sum - m_wide) : macc_sum[OW-1:0];
        end else begin
            n_macc = r_macc;
        end
        n_mp = (mp_dbl >= m_wide) ? OW'(mp_dbl - m_wide) : mp_dbl[OW-1:0];
    end

    always_comb begin
        inv_ok    = (r_m != '0) && (r_r0 == OW'(1));
        res_valid = inv_ok && ((r_op == OP_INV) || (r_op == OP_DIV));
        if (!res_valid) begin
            res_value = '0;
        end else if (r_op == OP_INV) begin
            res_value = inv;
        end else begin
            res_value = r_macc;
        end
        o_status.r1_zero  = (r_r1 == '0);
        o_status.need_mul = res_valid && (r_op == OP_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_opcode'(i_opcode);
            r_a  <= i_value_a;
            r_m  <= i_modulus;
            r_s0 <= CW'(1);
            r_s1 <= '0;
            r_t0 <= '0;
            r_t1 <= CW'(1);
            unique case (t_opcode'(i_opcode))
                OP_GCD: begin
                    r_r0 <= i_value_a;
                    r_r1 <= i_value_b;
                end
                OP_INV: begin
                    r_r0 <= i_value_a;
                    r_r1 <= i_modulus;
                end
                OP_DIV: begin
                    r_r0 <= i_value_b;
                    r_r1 <= i_modulus;
                end
                OP_NONE: begin
                    r_r0 <= '0;
                    r_r1 <= '0;
                end
            endcase
        end else if (i_cmd.update) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_s0 <= r_s1;
            r_s1 <= r_s0 - r_acc_s;
            r_t0 <= r_t1;
            r_t1 <= r_t0 - r_acc_t;
        end

        if (i_cmd.div_start) begin
            r_dvd   <= i_cmd.div_mod ? r_a : r_r0;
            r_dvs   <= i_cmd.div_mod ? r_m : r_r1;
            r_rem   <= '0;
            r_acc_s <= '0;
            r_acc_t <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd   <= {r_dvd[OW-2:0], 1'b0};
            r_rem   <= n_rem;
            // quotient bits arrive msb first, so q*s1 builds up by shift and add
            r_acc_s <= {r_acc_s[CW-2:0], 1'b0} + (q_bit ? r_s1 : CW'(0));
            r_acc_t <= {r_acc_t[CW-2:0], 1'b0} + (q_bit ? r_t1 : CW'(0));
        end

        if (i_cmd.mul_start) begin
            r_mp   <= r_rem;
            r_mq   <= inv;
            r_macc <= '0;
        end else if (i_cmd.mul_step) begin
            r_mp   <= n_mp;
            r_mq   <= {1'b0, r_mq[OW-1:1]};
            r_macc <= n_macc;
        end

        if (i_cmd.out_load) begin
            if (r_op == OP_NONE) begin
                r_o_gcd   <= '0;
                r_o_x     <= '0;
                r_o_y     <= '0;
                r_o_value <= '0;
                r_o_valid <= 1'b0;
            end else begin
                r_o_gcd   <= r_r0;
                r_o_x     <= r_s0;
                r_o_y     <= r_t0;
                r_o_value <= res_value;
                r_o_valid <= res_valid;
            end
        end
    end

    assign o_gcd_value    = r_o_gcd;
    assign o_coeff_x      = r_o_x;
    assign o_coeff_y      = r_o_y;
    assign o_result_value = r_o_value;
    assign o_result_valid = r_o_valid;

endmodule

// ----- sv/mid_ctrl.sv -----
// ----------------------------------------------------------------------------
// mid_ctrl
// Controller: sequences the euclid loop, the mod-m reduction and the modular
// multiply, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mid_ctrl #(
    parameter int DATA_WIDTH = mid_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_opcode,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output mid_pkg::t_cmd     o_cmd,
    input  mid_pkg::t_status  i_status
);
    import mid_pkg::*;

    localparam int OW    = DATA_WIDTH - 1;
    localparam int CNT_W = $clog2(OW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_REDUCE,
        S_MSTART,
        S_MUL,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic              accept;
    logic              out_free;
    logic              cnt_done;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign cnt_done = (r_cnt == '0);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (t_opcode'(i_opcode) == OP_NONE) ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.r1_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_status.need_mul) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_mod   = 1'b1;
                    n_state         = S_REDUCE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (cnt_done) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_REDUCE: begin
                o_cmd.div_step = 1'b1;
                if (cnt_done) n_state = S_MSTART;
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (cnt_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.div_start || o_cmd.mul_start) begin
                r_cnt <= CNT_W'(OW - 1);
            end else if (!cnt_done) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = !(r_state == S_IDLE) || (accept && 1'b0);
    assign o_valid = r_out_valid;

endmodule

// ----- sv/modular_inverse_divide_top.sv -----
// ----------------------------------------------------------------------------
// modular_inverse_divide_top
// Extended euclid gcd, modular inverse and modular divide, one request at a
// time.
// ----------------------------------------------------------------------------
// sequence: each euclid step is a check, one bit-serial division and an
//   update; a divide request adds the mod-m reduction and the modular multiply
// throughput: one request in flight; the next is taken once the result is in
//   the output register
// reset: synchronous active-low i_rst_n clears the controller and the output valid
module modular_inverse_divide_top #(
    parameter int DATA_WIDTH = mid_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [DATA_WIDTH-2:0]        i_value_a,
    input  logic [DATA_WIDTH-2:0]        i_value_b,
    input  logic [DATA_WIDTH-2:0]        i_modulus,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [DATA_WIDTH-2:0]        o_gcd_value,
    output logic signed [DATA_WIDTH-1:0] o_coeff_x,
    output logic signed [DATA_WIDTH-1:0] o_coeff_y,
    output logic [DATA_WIDTH-2:0]        o_result_value,
    output logic                         o_result_valid
);
    import mid_pkg::*;

    t_cmd    cmd;
    t_status status;

    mid_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    mid_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_opcode       (i_opcode),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .i_modulus      (i_modulus),
        .o_gcd_value    (o_gcd_value),
        .o_coeff_x      (o_coeff_x),
        .o_coeff_y      (o_coeff_y),
        .o_result_value (o_result_value),
        .o_result_valid (o_result_valid)
    );

    // an inverse only exists for coprime operands
    a_valid_gcd_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_valid) |-> (o_gcd_value == (DATA_WIDTH-1)'(1)))
        else $error("result flagged valid with gcd other than one");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_valid) |-> (o_result_value == '0))
        else $error("invalid result carries a nonzero value");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a transfer");

endmodule

// ----- tb/tb_modular_inverse_divide_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_divide_top
// Self-checking bench for the extended euclid / modular inverse / modular
// divide block. A queue-fed driver sends directed corner requests, then
// random requests in four idling phases. A clocked monitor compares each
// result transfer with a locally computed prediction.
// ----------------------------------------------------------------------------
module tb_modular_inverse_divide_top;
    import mid_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int RANDOM_PER_PHASE = 87;
    localparam int DRAIN_CYCLES = 1700;

    typedef struct {
        t_opcode       op;
        logic [DW-2:0] a;
        logic [DW-2:0] b;
        logic [DW-2:0] m;
    } t_modinv_request;

    typedef struct {
        logic [DW-2:0]        gcd;
        logic signed [DW-1:0] coeff_x;
        logic signed [DW-1:0] coeff_y;
        logic [DW-2:0]        value;
        logic                 valid;
    } t_modinv_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    logic [1:0]           i_opcode = 2'b00;
    logic [DW-2:0]        i_value_a = '0;
    logic [DW-2:0]        i_value_b = '0;
    logic [DW-2:0]        i_modulus = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [DW-2:0]        o_gcd_value;
    logic signed [DW-1:0] o_coeff_x;
    logic signed [DW-1:0] o_coeff_y;
    logic [DW-2:0]        o_result_value;
    logic                 o_result_valid;

    t_modinv_request modinv_request_q[$];
    t_modinv_result  modinv_expect_q[$];
    t_modinv_request next_req;
    t_modinv_result  exp_res;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int n_sent = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_with_inverse = 0;
    int n_errors = 0;

    modular_inverse_divide_top #(
        .DATA_WIDTH(DW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_value_a     (i_value_a),
        .i_value_b     (i_value_b),
        .i_modulus     (i_modulus),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_gcd_value   (o_gcd_value),
        .o_coeff_x     (o_coeff_x),
        .o_coeff_y     (o_coeff_y),
        .o_result_value(o_result_value),
        .o_result_valid(o_result_valid)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // extended euclid on the selected pair, then inverse or quotient mod m
    function automatic t_modinv_result modinv_predict(t_opcode op, logic [DW-2:0] a,
                                                      logic [DW-2:0] b, logic [DW-2:0] m);
        t_modinv_result res;
        longint r0, r1, s0, s1, t0, t1, q, tmp, ml, inv;
        res.gcd = '0;
        res.coeff_x = '0;
        res.coeff_y = '0;
        res.value = '0;
        res.valid = 1'b0;
        if (op == OP_NONE)
            return res;
        ml = m;
        case (op)
            OP_GCD: begin
                r0 = a;
                r1 = b;
            end
            OP_INV: begin
                r0 = a;
                r1 = ml;
            end
            default: begin
                r0 = b;
                r1 = ml;
            end
        endcase
        s0 = 1;
        s1 = 0;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = s0 - q * s1;
            s0 = s1;
            s1 = tmp;
            tmp = t0 - q * t1;
            t0 = t1;
            t1 = tmp;
        end
        res.gcd = r0[DW-2:0];
        res.coeff_x = s0[DW-1:0];
        res.coeff_y = t0[DW-1:0];
        if (op != OP_GCD && ml != 0 && r0 == 1) begin
            inv = s0 % ml;
            if (inv < 0)
                inv += ml;
            res.valid = 1'b1;
            if (op == OP_INV)
                res.value = inv[DW-2:0];
            else begin
                tmp = ((longint'(a) % ml) * inv) % ml;
                res.value = tmp[DW-2:0];
            end
        end
        return res;
    endfunction

    // mostly short operands to keep euclid runs short, some full width
    function automatic logic [DW-2:0] rand_operand();
        logic [31:0] raw;
        int w;
        raw = $urandom();
        w = $urandom_range(31, 0);
        if (w == 0)
            return '0;
        if ($urandom_range(31, 0) == 0)
            return '1;
        if ($urandom_range(2, 0) == 0)
            w = 31;
        return (DW-1)'(raw >> (32 - w));
    endfunction

    function automatic logic [DW-2:0] rand_prime();
        case ($urandom_range(5, 0))
            0: return 31'd2;
            1: return 31'd7;
            2: return 31'd65537;
            3: return 31'd998244353;
            4: return 31'd1000000007;
            default: return 31'd2147483647;
        endcase
    endfunction

    task automatic add_request(t_opcode op, logic [DW-2:0] a, logic [DW-2:0] b,
                               logic [DW-2:0] m);
        t_modinv_request req;
        req.op = op;
        req.a = a;
        req.b = b;
        req.m = m;
        modinv_request_q.insert(modinv_request_q.size(), req);
        n_sent++;
    endtask

    task automatic add_random_request();
        int sel;
        t_opcode op;
        logic [DW-2:0] m;
        sel = $urandom_range(99, 0);
        if (sel < 28)
            op = OP_GCD;
        else if (sel < 60)
            op = OP_INV;
        else if (sel < 92)
            op = OP_DIV;
        else if (sel < 96)
            op = OP_NONE;
        else
            op = ($urandom_range(1, 0) == 0) ? OP_INV : OP_DIV;
        m = (sel >= 96) ? '0 : rand_operand();
        if ((op == OP_INV || op == OP_DIV) && sel < 96 && $urandom_range(3, 0) == 0)
            m = rand_prime();
        add_request(op, rand_operand(), rand_operand(), m);
    endtask

    task automatic report_field(string field, longint exp_v, longint act_v);
        n_errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
    endtask

    // driver: holds a payload until transfer, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                modinv_expect_q.insert(modinv_expect_q.size(),
                                       modinv_predict(t_opcode'(i_opcode), i_value_a,
                                                      i_value_b, i_modulus));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (modinv_request_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    next_req = modinv_request_q.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= next_req.op;
                    i_value_a <= next_req.a;
                    i_value_b <= next_req.b;
                    i_modulus <= next_req.m;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (modinv_expect_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: result transfer with nothing expected, expected none, got gcd %0d",
                             $time, o_gcd_value);
                end else begin
                    exp_res = modinv_expect_q.pop_front();
                    n_checked++;
                    if (exp_res.valid)
                        n_with_inverse++;
                    if (o_gcd_value !== exp_res.gcd)
                        report_field("gcd_value", exp_res.gcd, o_gcd_value);
                    if (o_coeff_x !== exp_res.coeff_x)
                        report_field("coeff_x", exp_res.coeff_x, o_coeff_x);
                    if (o_coeff_y !== exp_res.coeff_y)
                        report_field("coeff_y", exp_res.coeff_y, o_coeff_y);
                    if (o_result_value !== exp_res.value)
                        report_field("result_value", exp_res.value, o_result_value);
                    if (o_result_valid !== exp_res.valid)
                        report_field("result_valid", exp_res.valid, o_result_valid);
                end
            end
            i_stall <= ($urandom_range(99, 0) < rx_stall_pct);
        end
    end

    initial begin
        int tx_pct[4];
        int rx_pct[4];
        tx_pct = '{0, 80, 0, 10};
        rx_pct = '{0, 0, 80, 10};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: zero and full-width operands, worst-case euclid chain
        add_request(OP_GCD, 31'd0, 31'd0, 31'd0);
        add_request(OP_GCD, 31'h7fffffff, 31'h7fffffff, 31'd5);
        add_request(OP_GCD, 31'd12345, 31'd0, 31'd0);
        add_request(OP_GCD, 31'd0, 31'd98765, 31'd3);
        add_request(OP_GCD, 31'd1836311903, 31'd1134903170, 31'd0);
        add_request(OP_GCD, 31'd240, 31'd46, 31'h7fffffff);
        add_request(OP_GCD, 31'd1, 31'h7fffffff, 31'd0);
        add_request(OP_INV, 31'd3, 31'd0, 31'd11);
        add_request(OP_INV, 31'd77, 31'd0, 31'd0);
        add_request(OP_INV, 31'd6, 31'd0, 31'd9);
        add_request(OP_INV, 31'd5, 31'd0, 31'd1);
        add_request(OP_INV, 31'h7fffffff, 31'd0, 31'd2147483646);
        add_request(OP_INV, 31'd2147483646, 31'd0, 31'h7fffffff);
        add_request(OP_INV, 31'd0, 31'd0, 31'd7);
        add_request(OP_INV, 31'd0, 31'd0, 31'd1);
        add_request(OP_DIV, 31'd10, 31'd3, 31'd7);
        add_request(OP_DIV, 31'd2147483646, 31'd2, 31'h7fffffff);
        add_request(OP_DIV, 31'd44, 31'd9, 31'd0);
        add_request(OP_DIV, 31'd5, 31'd4, 31'd6);
        add_request(OP_DIV, 31'd9, 31'd5, 31'd1);
        add_request(OP_DIV, 31'd1836311903, 31'd1134903170, 31'h7fffffff);
        add_request(OP_DIV, 31'd0, 31'd0, 31'd5);
        add_request(OP_NONE, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        add_request(OP_NONE, 31'd0, 31'd0, 31'd0);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                add_random_request();
            while (modinv_request_q.size() != 0)
                @(posedge i_clk);
        end

        while (n_accepted != n_sent || modinv_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results (gcd, inverse, divide, unused opcode) over four idling phases",
                 n_checked);
        $display("%0d of them carried an existing inverse, %0d field mismatches",
                 n_with_inverse, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // generous bound over the slowest legal run
    initial begin
        #25000000;
        $display("timeout: %0d of %0d requests checked", n_checked, n_sent);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
